FILE: rtl/cabb_pkg.sv
// shared types and constants for the clipped alpha blend blitter
// no dependencies; imported by cabb_mix and clipped_alpha_blend_blitter_core
package cabb_pkg;

  // default sprite store geometry
  localparam int MaxSpriteWidthDef  = 128;
  localparam int MaxSpriteHeightDef = 128;

  // blend scale: 255 * 256, and half of it for round-half-up
  localparam logic [15:0] FullScale = 16'd65280;
  localparam logic [23:0] HalfScale = 24'd32640;

  // global alpha reset value and ceiling (1.0 in Q1.8)
  localparam logic [8:0] AlphaOne = 9'd256;

  // item operation codes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_BLEND = 1'b1
  } op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_POS_X         = 3'd0,
    CFG_POS_Y         = 3'd1,
    CFG_SPRITE_WIDTH  = 3'd2,
    CFG_SPRITE_HEIGHT = 3'd3,
    CFG_GLOBAL_ALPHA  = 3'd4
  } cfg_idx_e;

  // sequencer states for one blend word
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MIX,
    ST_DONE
  } blit_state_e;

  // stage enables from the sequencer to the mixer
  typedef struct packed {
    logic load_s1;
    logic load_s2;
  } mix_ctl_t;

endpackage

FILE: rtl/cabb_store.sv
// sprite pixel store: one write port, one read port, registered read data
// no dependencies
module cabb_store #(
  parameter int Depth = 16384,
  parameter int AddrW = 14
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [31:0]      wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [31:0]      rd_data_o
);

  logic [31:0] mem [Depth];
  logic [31:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/cabb_mix.sv
// two-stage per-channel alpha mixer with divide by 65280 on the output
// depends on cabb_pkg (scale constants, mix_ctl_t)
module cabb_mix (
  input  logic               clk_i,
  input  cabb_pkg::mix_ctl_t ctl_i,
  input  logic [31:0]        src_pixel_i,
  input  logic [31:0]        dst_pixel_i,
  input  logic [8:0]         global_alpha_i,
  output logic [23:0]        mix_rgb_o
);

  import cabb_pkg::*;

  logic [15:0] alpha_q;
  logic [23:0] src_rgb_q;
  logic [15:0] alpha_d;
  logic [15:0] inv_alpha;
  logic [23:0] num_q [3];
  logic [23:0] num_d [3];

  // num / 65280 = floor(floor(num / 256) / 255), the outer one by reciprocal
  function automatic logic [7:0] div_full_scale(input logic [23:0] num);
    logic [15:0] x;
    logic [16:0] t;
    x = num[23:8];
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // stage 1: effective alpha from source alpha and global alpha, at most 255 * 256
  assign alpha_d = 16'(src_pixel_i[31:24]) * 16'(global_alpha_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_s1) begin
      alpha_q   <= alpha_d;
      src_rgb_q <= src_pixel_i[23:0];
    end
  end

  assign inv_alpha = FullScale - alpha_q;

  // stage 2: weighted sum per channel, then scale down
  for (genvar c = 0; c < 3; c++) begin : g_chan
    always_comb begin
      num_d[c] = 24'(dst_pixel_i[8*c +: 8]) * 24'(inv_alpha)
               + 24'(src_rgb_q[8*c +: 8]) * 24'(alpha_q)
               + HalfScale;
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.load_s2) begin
        num_q[c] <= num_d[c];
      end
    end

    assign mix_rgb_o[8*c +: 8] = div_full_scale(num_q[c]);
  end

endmodule

FILE: rtl/clipped_alpha_blend_blitter_core.sv
// clipped alpha blend blitter, top level
// load word: written to the sprite store at acceptance if in range, no result
// blend word: result registered in turn after store read, alpha and sum + divide;
// next word accepted as the result is registered, once the output is free
// blends run one at a time through the single store read port and the read-then-mix sequence
// async active-low reset clears control and config; sprite store is not cleared
module clipped_alpha_blend_blitter_core #(
  parameter int MAX_SPRITE_WIDTH  = cabb_pkg::MaxSpriteWidthDef,
  parameter int MAX_SPRITE_HEIGHT = cabb_pkg::MaxSpriteHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] pixel_value_i,
  input  logic [11:0] column_i,
  input  logic [11:0] row_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_pixel_o,
  output logic        covered_o
);

  import cabb_pkg::*;

  localparam int Depth = MAX_SPRITE_WIDTH * MAX_SPRITE_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int WW    = $clog2(MAX_SPRITE_WIDTH + 1);
  localparam int HW    = $clog2(MAX_SPRITE_HEIGHT + 1);

  // config registers
  logic [12:0] pos_x_q, pos_y_q;
  logic [7:0]  width_q, height_q;
  logic [8:0]  alpha_q;

  logic [WW-1:0] w_sat;
  logic [HW-1:0] h_sat;
  logic [8:0]    alpha_sat;

  logic        in_acc, is_blend, load_ok;
  logic [13:0] dx, dy;
  logic        cover_d;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic        wr_en, rd_en;
  logic [31:0] src_pixel;

  logic [31:0] dst_q;
  logic        cov_q;

  blit_state_e state_q, state_d;
  mix_ctl_t    mix_ctl;
  logic        out_free, out_load;
  logic [23:0] mix_rgb;

  logic        out_valid_q;
  logic [31:0] result_q;
  logic        covered_q;

  // config writes, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      width_q  <= '0;
      height_q <= '0;
      alpha_q  <= AlphaOne;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POS_X:         pos_x_q  <= cfg_data_i;
        CFG_POS_Y:         pos_y_q  <= cfg_data_i;
        CFG_SPRITE_WIDTH:  width_q  <= cfg_data_i[7:0];
        CFG_SPRITE_HEIGHT: height_q <= cfg_data_i[7:0];
        CFG_GLOBAL_ALPHA:  alpha_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // saturated sprite size and opacity
  assign w_sat = (int'(width_q) > MAX_SPRITE_WIDTH) ? WW'(MAX_SPRITE_WIDTH) : WW'(width_q);
  assign h_sat = (int'(height_q) > MAX_SPRITE_HEIGHT) ? HW'(MAX_SPRITE_HEIGHT)
                                                      : HW'(height_q);
  assign alpha_sat = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;

  // input acceptance
  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_blend = (op_e'(operation_i) == OP_BLEND);

  // sprite load address with range check
  assign load_ok = (int'(column_i) < MAX_SPRITE_WIDTH) && (int'(row_i) < MAX_SPRITE_HEIGHT);
  assign wr_en   = in_acc && !is_blend && load_ok;
  assign wr_addr = AddrW'(int'(row_i) * MAX_SPRITE_WIDTH + int'(column_i));

  // coverage test against the placed sprite rectangle
  assign dx = {2'b00, column_i} - {pos_x_q[12], pos_x_q};
  assign dy = {2'b00, row_i} - {pos_y_q[12], pos_y_q};
  assign cover_d = !dx[13] && !dy[13]
                && ({1'b0, dx[12:0]} < 14'(w_sat))
                && ({1'b0, dy[12:0]} < 14'(h_sat));

  // rows are stored bottom-up
  assign rd_en   = in_acc && is_blend;
  assign rd_addr = cover_d
      ? AddrW'((int'(h_sat) - 1 - int'(dy[12:0])) * MAX_SPRITE_WIDTH + int'(dx[12:0]))
      : '0;

  cabb_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (pixel_value_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (src_pixel)
  );

  // destination word and coverage held for the blend in flight
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      dst_q <= pixel_value_i;
      cov_q <= cover_d;
    end
  end

  // blend sequencer
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // stall is low in idle and in done with a free output, so a valid blend is taken there
  always_comb begin
    state_d         = state_q;
    mix_ctl.load_s1 = 1'b0;
    mix_ctl.load_s2 = 1'b0;
    out_load        = 1'b0;
    in_stall_o      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && is_blend) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mix_ctl.load_s1 = 1'b1;
        state_d         = ST_MIX;
      end
      ST_MIX: begin
        mix_ctl.load_s2 = 1'b1;
        state_d         = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          in_stall_o = 1'b0;
          state_d    = (in_valid_i && is_blend) ? ST_READ : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  cabb_mix u_mix (
    .clk_i          (clk_i),
    .ctl_i          (mix_ctl),
    .src_pixel_i    (src_pixel),
    .dst_pixel_i    (dst_q),
    .global_alpha_i (alpha_sat),
    .mix_rgb_o      (mix_rgb)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q  <= cov_q ? {8'h00, mix_rgb} : dst_q;
      covered_q <= cov_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_pixel_o = result_q;
  assign covered_o      = covered_q;

endmodule
